/* hw/rtl/csv_field_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Shared assertion forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Property must hold at every clock edge out of reset
`define CSV_TOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold whenever the antecedent holds
`define CSV_TOK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CSV_TOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/csv_tok_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Event and configuration types, character codes and queue sizing.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  // Event codes carried on the output tuser
  typedef enum logic [1:0] {
    EvField  = 2'd0,
    EvRecord = 2'd1,
    EvError  = 2'd2
  } ev_kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegDelimiter   = 3'd0,
    RegQuote       = 3'd1,
    RegEscapeA     = 3'd2,
    RegEscapeB     = 3'd3,
    RegEscapeCount = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIndexBits = 3;

  // Reset values of the configuration registers
  localparam logic [7:0] DelimiterReset   = 8'd44;
  localparam logic [7:0] QuoteReset       = 8'd34;
  localparam logic [7:0] EscapeAReset     = 8'd34;
  localparam logic [7:0] EscapeBReset     = 8'd92;
  localparam logic [1:0] EscapeCountReset = 2'd2;

  // Line end characters
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  // Events per byte and event queue sizing
  localparam int unsigned MaxEvents  = 3;
  localparam int unsigned EvCntBits  = 2;
  localparam int unsigned EvqDepth   = 4;
  localparam int unsigned EvqPtrBits = 2;
  localparam int unsigned EvqCntBits = 3;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic [7:0] escape_char_a;
    logic [7:0] escape_char_b;
    logic [1:0] escape_count;
  } cfg_t;

  typedef struct packed {
    ev_kind_e    event_kind;
    logic [31:0] field_begin;
    logic [31:0] field_finish;
    logic        final_event;
  } ev_t;

endpackage

/* hw/rtl/csv_tok_core.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Parse state and per-byte event generation, up to three events per byte.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csv_tok_core #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      step_i,
  input  logic [7:0]                                byte_i,
  input  logic                                      last_i,
  input  csv_tok_pkg::cfg_t                         cfg_i,
  output csv_tok_pkg::ev_t [csv_tok_pkg::MaxEvents-1:0] events_o,
  output logic [csv_tok_pkg::EvCntBits-1:0]         ev_cnt_o
);

  typedef enum logic [2:0] {
    ModeStart  = 3'd0,
    ModeSimple = 3'd1,
    ModeQuoted = 3'd2,
    ModeEscape = 3'd3,
    ModeAfter  = 3'd4
  } mode_e;

  localparam int unsigned WideBits = OFFSET_BITS + 32;
  localparam logic [WideBits-1:0] OutMax = WideBits'(32'hFFFF_FFFF);
  localparam logic [csv_tok_pkg::EvCntBits-1:0] EvOne = csv_tok_pkg::EvCntBits'(1);

  mode_e                  mode_q, mode_d, mode_eff;
  logic                   pend_q, pend_d;
  logic                   after_delim_q, after_delim_d;
  logic                   rec_open_q, rec_open_d;
  logic                   err_q, err_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] cfb_q, cfb_d;
  logic [OFFSET_BITS-1:0] nxt;
  logic [OFFSET_BITS-1:0] pos_prev;
  logic                   is_esc;
  logic                   is_delim, is_quote, is_lf, is_cr;
  logic                   go;
  logic [csv_tok_pkg::EvCntBits-1:0] n;
  csv_tok_pkg::ev_t [csv_tok_pkg::MaxEvents-1:0] ev;

  // Clamp an offset to the 32-bit output range
  function automatic logic [31:0] sat32(input logic [OFFSET_BITS-1:0] v);
    logic [WideBits-1:0] wide;
    wide = WideBits'(v);
    if (wide > OutMax) begin
      sat32 = 32'hFFFF_FFFF;
    end else begin
      sat32 = wide[31:0];
    end
  endfunction

  function automatic csv_tok_pkg::ev_t mk_ev(input csv_tok_pkg::ev_kind_e k,
                                             input logic [OFFSET_BITS-1:0] b,
                                             input logic [OFFSET_BITS-1:0] f);
    csv_tok_pkg::ev_t e;
    e.event_kind   = k;
    e.field_begin  = sat32(b);
    e.field_finish = sat32(f);
    e.final_event  = 1'b0;
    mk_ev = e;
  endfunction

  // Character classes for the current byte
  assign is_delim = (byte_i == cfg_i.delimiter_char);
  assign is_quote = (byte_i == cfg_i.quote_char);
  assign is_lf    = (byte_i == csv_tok_pkg::CharLf);
  assign is_cr    = (byte_i == csv_tok_pkg::CharCr);
  assign is_esc   = ((cfg_i.escape_count != 2'd0) && (byte_i == cfg_i.escape_char_a)) ||
                    (cfg_i.escape_count[1] && (byte_i == cfg_i.escape_char_b));

  // Saturating position and the offset just before it
  assign nxt      = (pos_q == '1) ? pos_q : pos_q + OFFSET_BITS'(1);
  assign pos_prev = (pos_q == '0) ? '0 : pos_q - OFFSET_BITS'(1);

  // Step one byte through the parser and collect its events
  always_comb begin
    mode_d        = mode_q;
    pend_d        = pend_q;
    after_delim_d = after_delim_q;
    rec_open_d    = rec_open_q;
    err_d         = err_q;
    pos_d         = nxt;
    cfb_d         = cfb_q;
    mode_eff      = mode_q;
    go            = 1'b1;
    n             = '0;
    ev            = '0;

    if (err_q) begin
      // Drop bytes until the buffer ends
      if (last_i) begin
        err_d = 1'b0;
        pos_d = '0;
      end
    end else begin
      // Empty field after a trailing delimiter
      if (after_delim_q) begin
        after_delim_d = 1'b0;
        if (is_lf || is_cr) begin
          ev[n] = mk_ev(csv_tok_pkg::EvField, pos_q, pos_q);
          n     = n + EvOne;
        end
      end
      rec_open_d = 1'b1;

      // Resolve a pending escape with this byte as lookahead
      if (mode_q == ModeEscape) begin
        if (is_quote) begin
          mode_d = ModeQuoted;
          go     = 1'b0;
          if (last_i) begin
            err_d = 1'b1;
          end
        end else begin
          if (pend_q) begin
            ev[n]    = mk_ev(csv_tok_pkg::EvField, cfb_q, pos_prev);
            n        = n + EvOne;
            mode_eff = ModeAfter;
          end else begin
            mode_eff = ModeQuoted;
          end
          mode_d = mode_eff;
          pend_d = 1'b0;
        end
      end

      if (go) begin
        unique case (mode_eff)
          ModeStart: begin
            if (is_lf) begin
              ev[n]      = mk_ev(csv_tok_pkg::EvRecord, pos_q, pos_q);
              n          = n + EvOne;
              rec_open_d = 1'b0;
            end else if (is_cr) begin
              mode_d = ModeStart;
            end else if (is_delim) begin
              ev[n] = mk_ev(csv_tok_pkg::EvField, pos_q, pos_q);
              n     = n + EvOne;
              if (last_i) begin
                ev[n] = mk_ev(csv_tok_pkg::EvField, nxt, nxt);
                n     = n + EvOne;
              end else begin
                after_delim_d = 1'b1;
              end
            end else if (is_quote) begin
              mode_d = ModeQuoted;
              cfb_d  = nxt;
            end else begin
              mode_d = ModeSimple;
              cfb_d  = pos_q;
            end
          end
          ModeSimple: begin
            if (is_delim) begin
              ev[n]  = mk_ev(csv_tok_pkg::EvField, cfb_q, pos_q);
              n      = n + EvOne;
              mode_d = ModeStart;
              if (last_i) begin
                ev[n] = mk_ev(csv_tok_pkg::EvField, nxt, nxt);
                n     = n + EvOne;
              end else begin
                after_delim_d = 1'b1;
              end
            end else if (is_lf) begin
              ev[n]      = mk_ev(csv_tok_pkg::EvField, cfb_q, pos_q);
              n          = n + EvOne;
              ev[n]      = mk_ev(csv_tok_pkg::EvRecord, pos_q, pos_q);
              n          = n + EvOne;
              rec_open_d = 1'b0;
              mode_d     = ModeStart;
            end else if (is_cr) begin
              ev[n]  = mk_ev(csv_tok_pkg::EvField, cfb_q, pos_q);
              n      = n + EvOne;
              mode_d = ModeStart;
            end
          end
          ModeQuoted: begin
            if (is_esc && !last_i) begin
              mode_d = ModeEscape;
              pend_d = is_quote;
            end else if (is_quote) begin
              ev[n]  = mk_ev(csv_tok_pkg::EvField, cfb_q, pos_q);
              n      = n + EvOne;
              mode_d = ModeAfter;
            end else if (last_i) begin
              err_d = 1'b1;
            end
          end
          default: begin
            // After a closing quote, and unused codes
            if (is_quote) begin
              mode_d = mode_eff;
            end else if (is_delim) begin
              mode_d = ModeStart;
              if (last_i) begin
                ev[n] = mk_ev(csv_tok_pkg::EvField, nxt, nxt);
                n     = n + EvOne;
              end else begin
                after_delim_d = 1'b1;
              end
            end else if (is_lf) begin
              ev[n]      = mk_ev(csv_tok_pkg::EvRecord, pos_q, pos_q);
              n          = n + EvOne;
              rec_open_d = 1'b0;
              mode_d     = ModeStart;
            end else if (is_cr) begin
              mode_d = ModeStart;
            end
          end
        endcase
      end

      // Close the buffer: open quote error or final end of record
      if (err_d) begin
        ev[n] = mk_ev(csv_tok_pkg::EvError, cfb_d, nxt);
        n     = n + EvOne;
      end else if (last_i && rec_open_d) begin
        ev[n] = mk_ev(csv_tok_pkg::EvRecord, nxt, nxt);
        n     = n + EvOne;
      end

      // Return to the buffer start state after the last byte
      if (last_i) begin
        mode_d        = ModeStart;
        pend_d        = 1'b0;
        after_delim_d = 1'b0;
        rec_open_d    = 1'b0;
        err_d         = 1'b0;
        pos_d         = '0;
        cfb_d         = '0;
      end
    end

    // Mark the last event of this byte
    if (n != '0) begin
      ev[n - EvOne].final_event = 1'b1;
    end
  end

  assign events_o = ev;
  assign ev_cnt_o = n;

  // Hold parse state, advance on each stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeStart;
      pend_q        <= 1'b0;
      after_delim_q <= 1'b0;
      rec_open_q    <= 1'b0;
      err_q         <= 1'b0;
      pos_q         <= '0;
      cfb_q         <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      pend_q        <= pend_d;
      after_delim_q <= after_delim_d;
      rec_open_q    <= rec_open_d;
      err_q         <= err_d;
      pos_q         <= pos_d;
      cfb_q         <= cfb_d;
    end
  end

  `CSV_TOK_ASSERT_IMPL(a_err_silent, err_q, ev_cnt_o == '0, "events produced while skipping")
  `CSV_TOK_ASSERT_NEXT(a_last_clears, step_i && last_i,
                       pos_q == '0 && mode_q == ModeStart && !err_q, "state not cleared at buffer end")
  `CSV_TOK_ASSERT_IMPL(a_delim_mode, after_delim_q, mode_q == ModeStart,
                       "pending empty field outside field start")

endmodule

/* hw/rtl/csv_tok_evq.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer event queue
// Small register queue taking up to three events per cycle, giving one.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_defines.svh"

module csv_tok_evq (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  csv_tok_pkg::ev_t [csv_tok_pkg::MaxEvents-1:0] push_i,
  input  logic [csv_tok_pkg::EvCntBits-1:0]             push_cnt_i,
  output logic                                          room_o,
  output logic                                          valid_o,
  input  logic                                          pop_i,
  output csv_tok_pkg::ev_t                              head_o
);

  csv_tok_pkg::ev_t                       mem_q [csv_tok_pkg::EvqDepth];
  logic [csv_tok_pkg::EvqPtrBits-1:0]     wr_ptr_q, rd_ptr_q;
  logic [csv_tok_pkg::EvqCntBits-1:0]     cnt_q;
  logic                                   pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];
  // Room for a full set of events from one byte
  assign room_o  = (cnt_q <= csv_tok_pkg::EvqCntBits'(csv_tok_pkg::EvqDepth -
                                                      csv_tok_pkg::MaxEvents));

  // Write incoming events in order behind the tail
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < csv_tok_pkg::MaxEvents; k++) begin
      if (csv_tok_pkg::EvCntBits'(k) < push_cnt_i) begin
        mem_q[wr_ptr_q + csv_tok_pkg::EvqPtrBits'(k)] <= push_i[k];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + csv_tok_pkg::EvqPtrBits'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + csv_tok_pkg::EvqPtrBits'(pop);
      cnt_q    <= cnt_q + csv_tok_pkg::EvqCntBits'(push_cnt_i) -
                  csv_tok_pkg::EvqCntBits'(pop);
    end
  end

  `CSV_TOK_ASSERT(a_cnt_max, cnt_q <= csv_tok_pkg::EvqCntBits'(csv_tok_pkg::EvqDepth),
                  "event queue overflow")
  `CSV_TOK_ASSERT_IMPL(a_push_room, push_cnt_i != '0, room_o, "events pushed without room")

endmodule

/* hw/rtl/csv_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Byte-stream CSV tokenizer emitting field, end-of-record and error events.
// ----------------------------------------------------------------------------
// Takes one byte per beat and accepts a new byte every cycle while the event
// queue has room. Each byte is held in an input register, stepped through the
// parser, and its zero to three events are written into a four-entry event
// queue that drives the output. A byte that causes one event or none sustains
// one byte per cycle while the output is ready; the queue drains at most one
// event per cycle, so bytes causing two or three events hold the input until
// the queue has room again. A byte passes through the input register and the
// event queue before its first event shows on the output. Output offsets
// saturate at 2^32-1; the internal position counter saturates at
// 2^OFFSET_BITS-1. Configuration writes are always accepted and should
// happen only while no byte is in flight.
module csv_field_tokenizer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  // event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] field_begin, [63:32] field_finish
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast,   // final_event
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [csv_tok_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  csv_tok_pkg::cfg_t                              cfg_q;
  logic                                           in_vld_q, in_vld_d;
  logic [7:0]                                     in_byte_q;
  logic                                           in_last_q;
  logic                                           step;
  logic                                           room;
  logic                                           s_fire;
  csv_tok_pkg::ev_t [csv_tok_pkg::MaxEvents-1:0]  events;
  logic [csv_tok_pkg::EvCntBits-1:0]              ev_cnt;
  logic [csv_tok_pkg::EvCntBits-1:0]              push_cnt;
  csv_tok_pkg::ev_t                               head;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_char <= csv_tok_pkg::DelimiterReset;
      cfg_q.quote_char     <= csv_tok_pkg::QuoteReset;
      cfg_q.escape_char_a  <= csv_tok_pkg::EscapeAReset;
      cfg_q.escape_char_b  <= csv_tok_pkg::EscapeBReset;
      cfg_q.escape_count   <= csv_tok_pkg::EscapeCountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        csv_tok_pkg::RegDelimiter:   cfg_q.delimiter_char <= cfg_data_i;
        csv_tok_pkg::RegQuote:       cfg_q.quote_char     <= cfg_data_i;
        csv_tok_pkg::RegEscapeA:     cfg_q.escape_char_a  <= cfg_data_i;
        csv_tok_pkg::RegEscapeB:     cfg_q.escape_char_b  <= cfg_data_i;
        csv_tok_pkg::RegEscapeCount: cfg_q.escape_count   <= cfg_data_i[1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Input register: step the held byte once the queue has room
  assign step          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || step;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  csv_tok_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg_q),
    .events_o (events),
    .ev_cnt_o (ev_cnt)
  );

  // Push events only for a stepped byte
  assign push_cnt = step ? ev_cnt : '0;

  csv_tok_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (events),
    .push_cnt_i (push_cnt),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .pop_i      (m_axis_tready),
    .head_o     (head)
  );

  // Output beat from the queue head
  assign m_axis_tdata = {head.field_finish, head.field_begin};
  assign m_axis_tuser = head.event_kind;
  assign m_axis_tlast = head.final_event;

endmodule

/* bench/tb_csv_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Streams CSV buffers into the tokenizer under several delimiter, quote and
// escape settings and checks every field, end-of-record and error event
// against a cycle-free predictor, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer;

  localparam int unsigned     OffsetBits = 32;
  localparam longint unsigned PosMax     = (64'd1 << OffsetBits) - 1;
  localparam longint unsigned OutMax     = 64'hFFFF_FFFF;
  localparam int unsigned     PhaseItems = 62;
  localparam int unsigned     HoldCycles = 300;
  localparam int unsigned     SettleCycles = 8;
  localparam int unsigned     CycleLimit = 400000;

  // Parser position inside a field
  typedef enum logic [2:0] {
    ModeStart,
    ModeUnquoted,
    ModeQuoted,
    ModeEscape,
    ModeClosed
  } parse_mode_e;

  // Predicts the events of each accepted byte and checks the event stream
  class token_scoreboard;
    csv_tok_pkg::cfg_t  cfg;
    parse_mode_e        mode;
    bit                 quote_pending;
    bit                 delim_pending;
    bit                 record_open;
    bit                 in_error;
    longint unsigned    pos;
    longint unsigned    content_begin;
    csv_tok_pkg::ev_t   expected_events[$];
    csv_tok_pkg::ev_t   step_events[$];
    int unsigned        mismatches;

    function new();
      cfg.delimiter_char = csv_tok_pkg::DelimiterReset;
      cfg.quote_char     = csv_tok_pkg::QuoteReset;
      cfg.escape_char_a  = csv_tok_pkg::EscapeAReset;
      cfg.escape_char_b  = csv_tok_pkg::EscapeBReset;
      cfg.escape_count   = csv_tok_pkg::EscapeCountReset;
      mismatches         = 0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      mode          = ModeStart;
      quote_pending = 1'b0;
      delim_pending = 1'b0;
      record_open   = 1'b0;
      in_error      = 1'b0;
      pos           = 0;
      content_begin = 0;
    endfunction

    function void write_reg(csv_tok_pkg::cfg_reg_e idx, logic [7:0] data);
      case (idx)
        csv_tok_pkg::RegDelimiter:   cfg.delimiter_char = data;
        csv_tok_pkg::RegQuote:       cfg.quote_char     = data;
        csv_tok_pkg::RegEscapeA:     cfg.escape_char_a  = data;
        csv_tok_pkg::RegEscapeB:     cfg.escape_char_b  = data;
        csv_tok_pkg::RegEscapeCount: cfg.escape_count   = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_offset(longint unsigned v);
      return (v > OutMax) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    function void add_event(csv_tok_pkg::ev_kind_e kind, longint unsigned b,
                            longint unsigned f);
      csv_tok_pkg::ev_t e;
      e.event_kind   = kind;
      e.field_begin  = clamp_offset(b);
      e.field_finish = clamp_offset(f);
      e.final_event  = 1'b0;
      step_events.push_back(e);
    endfunction

    // A count of three behaves as two
    function bit is_escape(logic [7:0] c);
      return (cfg.escape_count >= 1 && c == cfg.escape_char_a) ||
             (cfg.escape_count >= 2 && c == cfg.escape_char_b);
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      longint unsigned  here;
      longint unsigned  next;
      bit               rerun;
      csv_tok_pkg::ev_t tail;
      here = pos;
      next = (pos >= PosMax) ? PosMax : pos + 1;

      // Swallow bytes after an error until the buffer ends
      if (in_error) begin
        if (last) clear_buffer();
        else pos = next;
        return;
      end

      // Delimiter followed by a line end closes an empty field
      if (delim_pending) begin
        delim_pending = 1'b0;
        if (c == csv_tok_pkg::CharLf || c == csv_tok_pkg::CharCr)
          add_event(csv_tok_pkg::EvField, here, here);
      end
      record_open = 1'b1;

      do begin
        rerun = 1'b0;
        case (mode)
          ModeStart: begin
            if (c == csv_tok_pkg::CharLf) begin
              add_event(csv_tok_pkg::EvRecord, here, here);
              record_open = 1'b0;
            end else if (c == csv_tok_pkg::CharCr) begin
              // leading carriage return: skip
            end else if (c == cfg.delimiter_char) begin
              add_event(csv_tok_pkg::EvField, here, here);
              if (last) add_event(csv_tok_pkg::EvField, next, next);
              else delim_pending = 1'b1;
            end else if (c == cfg.quote_char) begin
              mode          = ModeQuoted;
              content_begin = next;
            end else begin
              mode          = ModeUnquoted;
              content_begin = here;
            end
          end
          ModeUnquoted: begin
            if (c == cfg.delimiter_char) begin
              add_event(csv_tok_pkg::EvField, content_begin, here);
              mode = ModeStart;
              if (last) add_event(csv_tok_pkg::EvField, next, next);
              else delim_pending = 1'b1;
            end else if (c == csv_tok_pkg::CharLf) begin
              add_event(csv_tok_pkg::EvField, content_begin, here);
              add_event(csv_tok_pkg::EvRecord, here, here);
              record_open = 1'b0;
              mode        = ModeStart;
            end else if (c == csv_tok_pkg::CharCr) begin
              add_event(csv_tok_pkg::EvField, content_begin, here);
              mode = ModeStart;
            end
          end
          ModeQuoted: begin
            if (is_escape(c) && !last) begin
              mode          = ModeEscape;
              quote_pending = (c == cfg.quote_char);
            end else if (c == cfg.quote_char) begin
              add_event(csv_tok_pkg::EvField, content_begin, here);
              mode = ModeClosed;
            end else if (last) begin
              in_error = 1'b1;
            end
          end
          ModeEscape: begin
            if (c == cfg.quote_char) begin
              mode = ModeQuoted;
              if (last) in_error = 1'b1;
            end else begin
              // The pending byte was a closing quote after all: reparse this byte
              if (quote_pending) begin
                add_event(csv_tok_pkg::EvField, content_begin, (here == 0) ? 0 : here - 1);
                mode = ModeClosed;
              end else begin
                mode = ModeQuoted;
              end
              quote_pending = 1'b0;
              rerun         = 1'b1;
            end
          end
          default: begin
            if (c == cfg.quote_char) begin
              // stray quote after the closing one: skip
            end else if (c == cfg.delimiter_char) begin
              mode = ModeStart;
              if (last) add_event(csv_tok_pkg::EvField, next, next);
              else delim_pending = 1'b1;
            end else if (c == csv_tok_pkg::CharLf) begin
              add_event(csv_tok_pkg::EvRecord, here, here);
              record_open = 1'b0;
              mode        = ModeStart;
            end else if (c == csv_tok_pkg::CharCr) begin
              mode = ModeStart;
            end
          end
        endcase
      end while (rerun);

      if (in_error) add_event(csv_tok_pkg::EvError, content_begin, next);
      else if (last && record_open) add_event(csv_tok_pkg::EvRecord, next, next);

      // Flag the last event of this byte and queue them all
      if (step_events.size() > 0) begin
        tail = step_events.pop_back();
        tail.final_event = 1'b1;
        step_events.push_back(tail);
      end
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
      step_events.delete();

      if (last) clear_buffer();
      else pos = next;
    endfunction

    function void report(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    endfunction

    function void check_event(csv_tok_pkg::ev_t got);
      csv_tok_pkg::ev_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual kind %0d begin %0h %s %0h %s %0b",
                 $time, got.event_kind, got.field_begin, "finish", got.field_finish, "last",
                 got.final_event);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      if (got.field_begin !== want.field_begin)
        report("field_begin", want.field_begin, got.field_begin);
      if (got.field_finish !== want.field_finish)
        report("field_finish", want.field_finish, got.field_finish);
      if (got.final_event !== want.final_event)
        report("final_event", 32'(want.final_event), 32'(got.final_event));
    endfunction
  endclass

  logic                                 clk_i;
  logic                                 rst_ni        = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [7:0]                           s_axis_tdata  = '0;
  logic                                 s_axis_tlast  = 1'b0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [63:0]                          m_axis_tdata;
  logic [1:0]                           m_axis_tuser;
  logic                                 m_axis_tlast;
  logic                                 cfg_valid_i   = 1'b0;
  logic                                 cfg_ready_o;
  logic [csv_tok_pkg::CfgIndexBits-1:0] cfg_index_i   = '0;
  logic [7:0]                           cfg_data_i    = '0;

  token_scoreboard sb;
  bit [7:0]        buf_bytes[$];
  int unsigned     burst_left;
  int unsigned     cycle_count;
  bit              hold_request;
  int unsigned     hold_left;
  int unsigned     stall_mode;
  int unsigned     stall_left;
  int unsigned     stall_tick;

  csv_field_tokenizer #(
    .OFFSET_BITS(OffsetBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample all handshakes mid-cycle, where every signal has settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(csv_tok_pkg::cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event(csv_tok_pkg::ev_t'({m_axis_tuser, m_axis_tdata[31:0],
                                           m_axis_tdata[63:32], m_axis_tlast}));
    end
  end

  // Stall the event stream on a changing pattern, with long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (stall_tick % 4 != 3);
      endcase
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one byte in bursts with random gaps and wait for its beat
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
  endtask

  // Stop offering and wait for every expected event, then for the pipeline
  task automatic settle(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input csv_tok_pkg::cfg_reg_e idx, input logic [7:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Write all five registers; random upper bits ride along with the count
  task automatic apply_config(input csv_tok_pkg::cfg_t c);
    write_reg(csv_tok_pkg::RegDelimiter, c.delimiter_char);
    write_reg(csv_tok_pkg::RegQuote, c.quote_char);
    write_reg(csv_tok_pkg::RegEscapeA, c.escape_char_a);
    write_reg(csv_tok_pkg::RegEscapeB, c.escape_char_b);
    write_reg(csv_tok_pkg::RegEscapeCount, {6'($urandom_range(0, 63)), c.escape_count});
    cfg_valid_i <= 1'b0;
  endtask

  // Any byte that plays no role under the current settings
  function automatic bit [7:0] plain_char();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == sb.cfg.delimiter_char || c == sb.cfg.quote_char ||
           c == sb.cfg.escape_char_a || c == sb.cfg.escape_char_b ||
           c == csv_tok_pkg::CharLf || c == csv_tok_pkg::CharCr);
    return c;
  endfunction

  function automatic bit [7:0] pick_char();
    bit [7:0] common[6] = '{8'h2C, 8'h22, 8'h5C, csv_tok_pkg::CharLf, csv_tok_pkg::CharCr,
                            8'h09};
    if ($urandom_range(0, 1) == 0) return common[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_field();
    int unsigned len;
    len = $urandom_range(0, 5);
    if ($urandom_range(0, 9) < 5) begin
      repeat (len) buf_bytes.push_back(plain_char());
    end else begin
      buf_bytes.push_back(sb.cfg.quote_char);
      repeat (len) begin
        case ($urandom_range(0, 5))
          0: buf_bytes.push_back(sb.cfg.delimiter_char);
          1: buf_bytes.push_back($urandom_range(0, 1) ? csv_tok_pkg::CharLf
                                                      : csv_tok_pkg::CharCr);
          2: begin
            // escaped quote inside the field
            if (sb.cfg.escape_count != 0) begin
              if (sb.cfg.escape_count == 1 || $urandom_range(0, 1) == 0)
                buf_bytes.push_back(sb.cfg.escape_char_a);
              else
                buf_bytes.push_back(sb.cfg.escape_char_b);
              buf_bytes.push_back(sb.cfg.quote_char);
            end
          end
          default: buf_bytes.push_back(plain_char());
        endcase
      end
      buf_bytes.push_back(sb.cfg.quote_char);
      // junk after the closing quote
      if ($urandom_range(0, 9) == 0)
        buf_bytes.push_back($urandom_range(0, 1) ? sb.cfg.quote_char : plain_char());
    end
  endfunction

  function automatic void add_record();
    int unsigned fields;
    fields = $urandom_range(1, 4);
    for (int unsigned f = 0; f < fields; f++) begin
      if (f != 0) buf_bytes.push_back(sb.cfg.delimiter_char);
      add_field();
    end
    case ($urandom_range(0, 9))
      6, 7: begin
        buf_bytes.push_back(csv_tok_pkg::CharCr);
        buf_bytes.push_back(csv_tok_pkg::CharLf);
      end
      8:       buf_bytes.push_back(csv_tok_pkg::CharCr);
      9:       ;
      default: buf_bytes.push_back(csv_tok_pkg::CharLf);
    endcase
  endfunction

  // Mostly well-formed buffers, some with an unclosed quote, some pure noise
  function automatic void build_buffer();
    int unsigned style;
    buf_bytes.delete();
    style = $urandom_range(0, 19);
    if (style < 17) begin
      repeat ($urandom_range(1, 3)) add_record();
      if (style < 14 && $urandom_range(0, 7) == 0) buf_bytes.push_back(sb.cfg.delimiter_char);
      if (style >= 14) begin
        buf_bytes.push_back(sb.cfg.quote_char);
        repeat ($urandom_range(0, 3)) buf_bytes.push_back(plain_char());
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 7))
          0:       buf_bytes.push_back(sb.cfg.delimiter_char);
          1:       buf_bytes.push_back(sb.cfg.quote_char);
          2:       buf_bytes.push_back(sb.cfg.escape_char_a);
          3:       buf_bytes.push_back(sb.cfg.escape_char_b);
          4:       buf_bytes.push_back(csv_tok_pkg::CharLf);
          5:       buf_bytes.push_back(csv_tok_pkg::CharCr);
          6:       buf_bytes.push_back(8'($urandom_range(0, 255)));
          default: buf_bytes.push_back(plain_char());
        endcase
      end
    end
    if (buf_bytes.size() == 0) buf_bytes.push_back(plain_char());
  endfunction

  initial begin : stimulus
    // {last, byte}: escapes, leading CR, empty fields, trailing delimiter,
    // unclosed quotes, delimiter before a line end
    bit [8:0]          directed_bytes[$] = '{
      9'h000, 9'h02C, 9'h022, 9'h078, 9'h022, 9'h022, 9'h05C, 9'h022,
      9'h022, 9'h02C, 9'h00D, 9'h00A, 9'h00D, 9'h0FF, 9'h12C,
      9'h022, 9'h061, 9'h15C,
      9'h022, 9'h022, 9'h122,
      9'h02C, 9'h10A};
    csv_tok_pkg::cfg_t phase_cfg[5];
    int unsigned       phase_count;
    bit                paused;

    sb = new();
    phase_cfg[0] = '{csv_tok_pkg::DelimiterReset, csv_tok_pkg::QuoteReset,
                     csv_tok_pkg::EscapeAReset, csv_tok_pkg::EscapeBReset,
                     csv_tok_pkg::EscapeCountReset};
    phase_cfg[1] = '{8'h3B, 8'h27, 8'h5C, 8'h27, 2'd1};
    phase_cfg[2] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 2'd0};
    phase_cfg[3] = '{8'hFF, 8'h00, 8'h00, 8'hFF, 2'd3};
    phase_cfg[4] = '{pick_char(), pick_char(), pick_char(), pick_char(),
                     2'($urandom_range(0, 3))};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    settle(SettleCycles);

    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      if (p != 0) apply_config(phase_cfg[p]);
      // Hold off the event stream while bytes keep coming
      if (p == 0) hold_request = 1'b1;
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        build_buffer();
        send_buffer();
        phase_count += buf_bytes.size();
        if (p == 2 && !paused && phase_count > PhaseItems / 2) begin
          settle(SettleCycles);
          paused = 1'b1;
        end
      end
      settle(SettleCycles);
    end

    settle(4 * SettleCycles);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
